// ===== sv/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg: shared widths, constants and tables for GPS time to calendar
// Field widths, pipeline depth, reciprocal constants for the fixed divisions.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int unsigned NUM_STAGES  = 7;
    localparam int unsigned FRONT_STAGES = 2;
    localparam int unsigned BACK_STAGES = NUM_STAGES - FRONT_STAGES;

    // field widths
    localparam int unsigned WEEK_W  = 13;
    localparam int unsigned SOW_W   = 40;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 26;
    localparam int unsigned MJD_W   = 17;
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 80;

    // internal widths
    localparam int unsigned DAYS_W = 3;   // whole days within the week, 0..6
    localparam int unsigned USD_W  = 37;  // microseconds within the day
    localparam int unsigned B_W    = 22;  // Meeus B
    localparam int unsigned N_W    = 24;  // 4*B - 489
    localparam int unsigned C_W    = 13;  // Meeus C
    localparam int unsigned G_W    = 9;   // B - D, day of year from March
    localparam int unsigned E_W    = 4;   // Meeus E
    localparam int unsigned REMH_W = 32;  // microseconds within the hour

    localparam logic [SOW_W-1:0] SOW_MAX_US    = 40'd604799999999;
    localparam logic [SOW_W-1:0] DAY_US        = 40'd86400000000;
    localparam logic [MJD_W-1:0] GPS_EPOCH_MJD = 17'd44244;

    // B = MJD + 2400001 + 1537, one more once alpha reaches 17
    localparam logic [B_W-1:0]   B_OFFSET  = 22'd2401538;
    localparam logic [MJD_W-1:0] ALPHA_MJD = 17'd88128;
    // C = floor((100B - 12210) / 36525) = floor((4B - 489) / 1461)
    localparam logic [N_W-1:0]   N_OFFSET  = 24'd489;
    localparam int unsigned      C_SHIFT   = 35;
    localparam logic [63:0]      C_DIV     = 64'd1461;
    localparam logic [63:0]      C_MULT64  = ((64'd1 << C_SHIFT) + C_DIV - 64'd1) / C_DIV;
    localparam int unsigned      C_MULT_W  = 25;
    localparam logic [C_W-1:0]   YEAR_OFS_LATE  = 13'd4716;
    localparam logic [C_W-1:0]   YEAR_OFS_EARLY = 13'd4715;
    localparam logic [10:0]      D_MULT    = 11'd1461;

    // hour = floor((us_day >> 10) / 3515625)
    localparam logic [USD_W-1:0] HOUR_US   = 37'd3600000000;
    localparam int unsigned      HOUR_PRE  = 10;
    localparam int unsigned      HOUR_X_W  = USD_W - HOUR_PRE;
    localparam int unsigned      HOUR_SHIFT = 49;
    localparam logic [63:0]      HOUR_DIV  = 64'd3515625;
    localparam logic [63:0]      HOUR_MULT64 =
        ((64'd1 << HOUR_SHIFT) + HOUR_DIV - 64'd1) / HOUR_DIV;
    localparam int unsigned      HOUR_MULT_W = 28;

    // minute = floor((rem_h >> 8) / 234375)
    localparam logic [REMH_W-1:0] MIN_US   = 32'd60000000;
    localparam int unsigned      MIN_PRE   = 8;
    localparam int unsigned      MIN_X_W   = REMH_W - MIN_PRE;
    localparam int unsigned      MIN_SHIFT = 42;
    localparam logic [63:0]      MIN_DIV   = 64'd234375;
    localparam logic [63:0]      MIN_MULT64 =
        ((64'd1 << MIN_SHIFT) + MIN_DIV - 64'd1) / MIN_DIV;
    localparam int unsigned      MIN_MULT_W = 25;

    // floor(30.6001 * e)
    function automatic logic [G_W-1:0] e_floor(input logic [E_W-1:0] e);
        logic [G_W-1:0] v;
        case (e)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/gtc_split.sv =====
// ----------------------------------------------------------------------------
// gtc_split: front stages of the converter
// Clamps seconds of week, splits it into whole days and microseconds of day,
// and forms the Modified Julian Day.
// ----------------------------------------------------------------------------
module gtc_split (
    input  logic                              i_clk,
    input  logic [gtc_pkg::FRONT_STAGES-1:0]  i_en,
    input  logic [gtc_pkg::WEEK_W-1:0]        i_gps_week,
    input  logic [gtc_pkg::SOW_W-1:0]         i_sow_us,
    output logic [gtc_pkg::MJD_W-1:0]         o_mjd,
    output logic [gtc_pkg::USD_W-1:0]         o_us_day
);

    function automatic logic [gtc_pkg::SOW_W-1:0] day_start(
        input logic [gtc_pkg::DAYS_W-1:0] d);
        logic [gtc_pkg::SOW_W-1:0] v;
        case (d)
            3'd1:    v = gtc_pkg::DAY_US;
            3'd2:    v = gtc_pkg::DAY_US * 40'd2;
            3'd3:    v = gtc_pkg::DAY_US * 40'd3;
            3'd4:    v = gtc_pkg::DAY_US * 40'd4;
            3'd5:    v = gtc_pkg::DAY_US * 40'd5;
            3'd6:    v = gtc_pkg::DAY_US * 40'd6;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [gtc_pkg::SOW_W-1:0]  r_sow,  n_sow;
    logic [gtc_pkg::MJD_W-1:0]  r_base, n_base;
    logic [gtc_pkg::MJD_W-1:0]  r_mjd,  n_mjd;
    logic [gtc_pkg::USD_W-1:0]  r_usd,  n_usd;
    logic [15:0]                week7;
    logic [gtc_pkg::DAYS_W-1:0] days;
    logic [gtc_pkg::SOW_W-1:0]  sow_rem;

    always_comb begin
        n_sow = (i_sow_us > gtc_pkg::SOW_MAX_US) ? gtc_pkg::SOW_MAX_US : i_sow_us;
        week7 = {i_gps_week, 3'b000} - 16'(i_gps_week);
        n_base = 17'(week7) + gtc_pkg::GPS_EPOCH_MJD;
    end

    // at most six day boundaries inside a week
    always_comb begin
        days = '0;
        for (int k = 1; k < 7; k++) begin
            if (r_sow >= day_start(3'(k))) begin
                days = 3'(k);
            end
        end
        sow_rem = r_sow - day_start(days);
        n_usd   = sow_rem[gtc_pkg::USD_W-1:0];
        n_mjd   = r_base + 17'(days);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sow  <= n_sow;
            r_base <= n_base;
        end
        if (i_en[1]) begin
            r_mjd <= n_mjd;
            r_usd <= n_usd;
        end
    end

    assign o_mjd    = r_mjd;
    assign o_us_day = r_usd;

endmodule

// ===== sv/gtc_date.sv =====
// ----------------------------------------------------------------------------
// gtc_date: Gregorian date pipeline
// Meeus steps on the day number: alpha, B, C, D, E, then day, month, year.
// ----------------------------------------------------------------------------
module gtc_date (
    input  logic                              i_clk,
    input  logic [gtc_pkg::BACK_STAGES-1:0]   i_en,
    input  logic [gtc_pkg::MJD_W-1:0]         i_mjd,
    output logic [gtc_pkg::YEAR_W-1:0]        o_year,
    output logic [gtc_pkg::MONTH_W-1:0]       o_month,
    output logic [gtc_pkg::DAY_W-1:0]         o_day,
    output logic [gtc_pkg::MJD_W-1:0]         o_mjd
);

    localparam int unsigned PROD_W = gtc_pkg::N_W + gtc_pkg::C_MULT_W;
    localparam logic [gtc_pkg::C_MULT_W-1:0] C_MULT =
        gtc_pkg::C_MULT64[gtc_pkg::C_MULT_W-1:0];

    logic [gtc_pkg::N_W-1:0]     r2_n, n2_n;
    logic [gtc_pkg::B_W-1:0]     r2_b, n2_b;
    logic [gtc_pkg::MJD_W-1:0]   r2_mjd;
    logic [gtc_pkg::C_W-1:0]     r3_c, n3_c;
    logic [gtc_pkg::B_W-1:0]     r3_b;
    logic [gtc_pkg::MJD_W-1:0]   r3_mjd;
    logic [gtc_pkg::G_W-1:0]     r4_g, n4_g;
    logic [gtc_pkg::C_W-1:0]     r4_c;
    logic [gtc_pkg::MJD_W-1:0]   r4_mjd;
    logic [gtc_pkg::E_W-1:0]     r5_e, n5_e;
    logic [gtc_pkg::G_W-1:0]     r5_g;
    logic [gtc_pkg::C_W-1:0]     r5_c;
    logic [gtc_pkg::MJD_W-1:0]   r5_mjd;
    logic [gtc_pkg::YEAR_W-1:0]  r6_year,  n6_year;
    logic [gtc_pkg::MONTH_W-1:0] r6_month, n6_month;
    logic [gtc_pkg::DAY_W-1:0]   r6_day,   n6_day;
    logic [gtc_pkg::MJD_W-1:0]   r6_mjd;
    logic [PROD_W-1:0]           c_prod;
    logic [23:0]                 d_full;
    logic [gtc_pkg::B_W-1:0]     g_full;
    logic [gtc_pkg::G_W-1:0]     dom_full;
    logic [gtc_pkg::C_W-1:0]     year_full;

    // alpha is 15..17 over the whole input range; only the step to 17 moves A
    always_comb begin
        n2_b = 22'(i_mjd) + gtc_pkg::B_OFFSET
             + 22'(i_mjd >= gtc_pkg::ALPHA_MJD);
        n2_n = {n2_b, 2'b00} - gtc_pkg::N_OFFSET;
    end

    always_comb begin
        c_prod = PROD_W'(r2_n) * PROD_W'(C_MULT);
        n3_c   = c_prod[gtc_pkg::C_SHIFT +: gtc_pkg::C_W];
    end

    always_comb begin
        d_full = 24'(r3_c) * 24'(gtc_pkg::D_MULT);
        g_full = r3_b - d_full[23:2];
        n4_g   = g_full[gtc_pkg::G_W-1:0];
    end

    // E is the largest k with B - D > floor(30.6001 k)
    always_comb begin
        n5_e = '0;
        for (int k = 1; k < 2 ** gtc_pkg::E_W; k++) begin
            if (r4_g > gtc_pkg::e_floor(gtc_pkg::E_W'(k))) begin
                n5_e = gtc_pkg::E_W'(k);
            end
        end
    end

    always_comb begin
        dom_full = r5_g - gtc_pkg::e_floor(r5_e);
        n6_day   = dom_full[gtc_pkg::DAY_W-1:0];
        n6_month = (r5_e < 4'd14) ? r5_e - 4'd1 : r5_e - 4'd13;
        year_full = (n6_month > 4'd2) ? r5_c - gtc_pkg::YEAR_OFS_LATE
                                      : r5_c - gtc_pkg::YEAR_OFS_EARLY;
        n6_year  = year_full[gtc_pkg::YEAR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_n   <= n2_n;
            r2_b   <= n2_b;
            r2_mjd <= i_mjd;
        end
        if (i_en[1]) begin
            r3_c   <= n3_c;
            r3_b   <= r2_b;
            r3_mjd <= r2_mjd;
        end
        if (i_en[2]) begin
            r4_g   <= n4_g;
            r4_c   <= r3_c;
            r4_mjd <= r3_mjd;
        end
        if (i_en[3]) begin
            r5_e   <= n5_e;
            r5_g   <= r4_g;
            r5_c   <= r4_c;
            r5_mjd <= r4_mjd;
        end
        if (i_en[4]) begin
            r6_year  <= n6_year;
            r6_month <= n6_month;
            r6_day   <= n6_day;
            r6_mjd   <= r5_mjd;
        end
    end

    assign o_year  = r6_year;
    assign o_month = r6_month;
    assign o_day   = r6_day;
    assign o_mjd   = r6_mjd;

endmodule

// ===== sv/gtc_tod.sv =====
// ----------------------------------------------------------------------------
// gtc_tod: time-of-day pipeline
// Splits microseconds of day into hour, minute and microsecond of minute.
// ----------------------------------------------------------------------------
module gtc_tod (
    input  logic                              i_clk,
    input  logic [gtc_pkg::BACK_STAGES-1:0]   i_en,
    input  logic [gtc_pkg::USD_W-1:0]         i_us_day,
    output logic [gtc_pkg::HOUR_W-1:0]        o_hour,
    output logic [gtc_pkg::MIN_W-1:0]         o_minute,
    output logic [gtc_pkg::SEC_W-1:0]         o_second_us
);

    localparam int unsigned HPROD_W = gtc_pkg::HOUR_X_W + gtc_pkg::HOUR_MULT_W;
    localparam int unsigned MPROD_W = gtc_pkg::MIN_X_W + gtc_pkg::MIN_MULT_W;
    localparam logic [gtc_pkg::HOUR_MULT_W-1:0] HOUR_MULT =
        gtc_pkg::HOUR_MULT64[gtc_pkg::HOUR_MULT_W-1:0];
    localparam logic [gtc_pkg::MIN_MULT_W-1:0] MIN_MULT =
        gtc_pkg::MIN_MULT64[gtc_pkg::MIN_MULT_W-1:0];

    logic [gtc_pkg::HOUR_W-1:0] r2_hour, n2_hour;
    logic [gtc_pkg::USD_W-1:0]  r2_usd;
    logic [gtc_pkg::REMH_W-1:0] r3_remh, n3_remh;
    logic [gtc_pkg::HOUR_W-1:0] r3_hour;
    logic [gtc_pkg::MIN_W-1:0]  r4_min, n4_min;
    logic [gtc_pkg::REMH_W-1:0] r4_remh;
    logic [gtc_pkg::HOUR_W-1:0] r4_hour;
    logic [gtc_pkg::SEC_W-1:0]  r5_sec, n5_sec;
    logic [gtc_pkg::MIN_W-1:0]  r5_min;
    logic [gtc_pkg::HOUR_W-1:0] r5_hour;
    logic [gtc_pkg::SEC_W-1:0]  r6_sec;
    logic [gtc_pkg::MIN_W-1:0]  r6_min;
    logic [gtc_pkg::HOUR_W-1:0] r6_hour;
    logic [HPROD_W-1:0]         h_prod;
    logic [gtc_pkg::USD_W-1:0]  h_rem;
    logic [MPROD_W-1:0]         m_prod;
    logic [gtc_pkg::REMH_W-1:0] m_rem;

    // 3.6e9 = 1024 * 3515625: drop the low bits, then exact reciprocal
    always_comb begin
        h_prod  = HPROD_W'(i_us_day[gtc_pkg::USD_W-1:gtc_pkg::HOUR_PRE])
                * HPROD_W'(HOUR_MULT);
        n2_hour = h_prod[gtc_pkg::HOUR_SHIFT +: gtc_pkg::HOUR_W];
    end

    always_comb begin
        h_rem   = r2_usd - 37'(r2_hour) * gtc_pkg::HOUR_US;
        n3_remh = h_rem[gtc_pkg::REMH_W-1:0];
    end

    // 6e7 = 256 * 234375
    always_comb begin
        m_prod = MPROD_W'(r3_remh[gtc_pkg::REMH_W-1:gtc_pkg::MIN_PRE])
               * MPROD_W'(MIN_MULT);
        n4_min = m_prod[gtc_pkg::MIN_SHIFT +: gtc_pkg::MIN_W];
    end

    always_comb begin
        m_rem  = r4_remh - 32'(r4_min) * gtc_pkg::MIN_US;
        n5_sec = m_rem[gtc_pkg::SEC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_hour <= n2_hour;
            r2_usd  <= i_us_day;
        end
        if (i_en[1]) begin
            r3_remh <= n3_remh;
            r3_hour <= r2_hour;
        end
        if (i_en[2]) begin
            r4_min  <= n4_min;
            r4_remh <= r3_remh;
            r4_hour <= r3_hour;
        end
        if (i_en[3]) begin
            r5_sec  <= n5_sec;
            r5_min  <= r4_min;
            r5_hour <= r4_hour;
        end
        if (i_en[4]) begin
            r6_sec  <= r5_sec;
            r6_min  <= r5_min;
            r6_hour <= r5_hour;
        end
    end

    assign o_hour      = r6_hour;
    assign o_minute    = r6_min;
    assign o_second_us = r6_sec;

endmodule

// ===== sv/gps_time_to_calendar.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_calendar: GPS week and seconds of week to Gregorian date/time
// Seven-stage pipeline with per-stage flow control.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one GPS time per request: full week number
//   and microseconds of week; values past the end of the week are clamped
//   to its last microsecond.
//   Master channel (o_m_*) gives year, month, day, hour, minute, microsecond
//   of minute and the Modified Julian Day, one result per request, in order.
//   Stages: an accepted request passes through seven register stages in
//   order: clamp, day split, B, C, D, E, output.
//   Throughput: one request per cycle unless stalled; each stage holds its own
//   valid bit and loads whenever it is empty or the stage after it moves.
//   Reset clears the valid bits only; the data path needs no reset.
//   When the receiver stalls, the output holds; earlier stages keep
//   filling bubbles, and o_s_tready drops only once all seven are full.
// ----------------------------------------------------------------------------
module gps_time_to_calendar (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: gps_week[12:0], sow_us[52:13], zero[55:53]
    input  logic [gtc_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: year[11:0], month[15:12], day[20:16], hour[25:21],
    //        minute[31:26], second_us[57:32], mjd_day[74:58], zero[79:75]
    output logic [gtc_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int unsigned PACK_W = gtc_pkg::YEAR_W + gtc_pkg::MONTH_W
        + gtc_pkg::DAY_W + gtc_pkg::HOUR_W + gtc_pkg::MIN_W
        + gtc_pkg::SEC_W + gtc_pkg::MJD_W;

    logic [gtc_pkg::NUM_STAGES-1:0] r_valid;
    logic [gtc_pkg::NUM_STAGES-1:0] stage_en;
    logic [gtc_pkg::MJD_W-1:0]      split_mjd;
    logic [gtc_pkg::USD_W-1:0]      split_usd;
    logic [gtc_pkg::YEAR_W-1:0]     year;
    logic [gtc_pkg::MONTH_W-1:0]    month;
    logic [gtc_pkg::DAY_W-1:0]      day;
    logic [gtc_pkg::MJD_W-1:0]      mjd_day;
    logic [gtc_pkg::HOUR_W-1:0]     hour;
    logic [gtc_pkg::MIN_W-1:0]      minute;
    logic [gtc_pkg::SEC_W-1:0]      second_us;

    // a stage loads when empty or when its successor moves
    always_comb begin
        stage_en[gtc_pkg::NUM_STAGES-1] = !r_valid[gtc_pkg::NUM_STAGES-1] || i_m_tready;
        for (int k = gtc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k < gtc_pkg::NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    gtc_split u_split (
        .i_clk      (i_clk),
        .i_en       (stage_en[gtc_pkg::FRONT_STAGES-1:0]),
        .i_gps_week (i_s_tdata[gtc_pkg::WEEK_W-1:0]),
        .i_sow_us   (i_s_tdata[gtc_pkg::WEEK_W +: gtc_pkg::SOW_W]),
        .o_mjd      (split_mjd),
        .o_us_day   (split_usd)
    );

    gtc_date u_date (
        .i_clk   (i_clk),
        .i_en    (stage_en[gtc_pkg::NUM_STAGES-1:gtc_pkg::FRONT_STAGES]),
        .i_mjd   (split_mjd),
        .o_year  (year),
        .o_month (month),
        .o_day   (day),
        .o_mjd   (mjd_day)
    );

    gtc_tod u_tod (
        .i_clk       (i_clk),
        .i_en        (stage_en[gtc_pkg::NUM_STAGES-1:gtc_pkg::FRONT_STAGES]),
        .i_us_day    (split_usd),
        .o_hour      (hour),
        .o_minute    (minute),
        .o_second_us (second_us)
    );

    assign o_s_tready = stage_en[0];
    assign o_m_tvalid = r_valid[gtc_pkg::NUM_STAGES-1];
    assign o_m_tdata  = {(gtc_pkg::OUT_TDATA_W - PACK_W)'(0),
                         mjd_day, second_us, minute, hour, day, month, year};

endmodule
